[hdl/wsm_pkg.sv]
// Package: types, constants and codes for the window stack manager.
`default_nettype none
package wsm_pkg;
  localparam int MAX_WINDOWS_DEF = 32;
  localparam int SCREEN_COORD_BITS_DEF = 12;
  localparam int TITLE_H = 24;
  localparam int BORDER_W = 2;
  localparam int CLOSE_INSET = 20;
  localparam int CLOSE_TOP = 8;
  localparam int CLOSE_SIZE = 12;
  localparam logic [12:0] SCREEN_W_RST = 13'd1024;
  localparam logic [12:0] SCREEN_H_RST = 13'd768;

  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_DESTROY = 3'd1;
  localparam logic [2:0] REQ_MOVE    = 3'd2;
  localparam logic [2:0] REQ_RESIZE  = 3'd3;
  localparam logic [2:0] REQ_RAISE   = 3'd4;
  localparam logic [2:0] REQ_MOTION  = 3'd5;
  localparam logic [2:0] REQ_BUTTON  = 3'd6;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam logic ADDR_SCREEN_W = 1'b0;
  localparam logic ADDR_SCREEN_H = 1'b1;

  localparam int SLOT_W = 32 + 16 + 16 + 15 + 15 + 32;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] left;
    logic [15:0] top;
    logic [14:0] width;
    logic [14:0] height;
    logic [31:0] color;
  } slot_t;
endpackage
`default_nettype wire

[hdl/window_stack_manager_top.sv]
// Top level: window stack manager with slot memory and request sequencer.
// Usage:
//  Requests enter as beats on the in_ channel (valid/ready); each gives
//  exactly one result beat on the out_ channel. One request is worked at a
//  time: in_ready is high only when the sequencer is idle and no result is
//  waiting, so a stalled receiver holds off the next request.
//  Slot data sit in one RAM (one read, one write a cycle, registered read).
//  Work per request: create, unused codes: straight to the result;
//   motion or button with no drag to move: drag check only;
//   move/resize: search, write; not found: full search; destroy, raise:
//   search up to the match, then shift the slots above it down by one;
//   motion while dragging: drag search and write back;
//   button press: top-down hit test, raise, drag search.
//  The next request can be taken in the cycle after its result is taken.
//  Reset clears stack depth, focus, drag and button state and centers the
//  cursor in the reset screen size. The slot RAM needs no clearing.
//  cfg_ writes to screen_width/height are taken any time and apply at the
//  next nonzero cursor motion.
`default_nettype none
module window_stack_manager_top #(
  parameter int MAX_WINDOWS = wsm_pkg::MAX_WINDOWS_DEF,
  parameter int SCREEN_COORD_BITS = wsm_pkg::SCREEN_COORD_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [31:0] in_win_id,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic [14:0] in_size_w,
  input  wire logic [14:0] in_size_h,
  input  wire logic [31:0] in_fill_color,
  input  wire logic signed [15:0] in_move_dx,
  input  wire logic signed [15:0] in_move_dy,
  input  wire logic        in_button_pressed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_focused_window,
  output logic [SCREEN_COORD_BITS-1:0] out_cursor_x,
  output logic [SCREEN_COORD_BITS-1:0] out_cursor_y,
  output logic [$clog2(MAX_WINDOWS+1)-1:0] out_window_total,
  output logic             out_dragging
);
  import wsm_pkg::*;

  localparam int AW = $clog2(MAX_WINDOWS);
  localparam int DW = $clog2(MAX_WINDOWS + 1);
  localparam int CB = SCREEN_COORD_BITS;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_FIND   = 11'b00000000010,  // search for req id, lowest slot
    S_APPLY  = 11'b00000000100,
    S_SHIFT  = 11'b00000001000,  // copy slot i+1 to i
    S_PUTTOP = 11'b00000010000,
    S_HIT    = 11'b00000100000,  // top-down hit test
    S_PRESS  = 11'b00001000000,
    S_DFIND  = 11'b00010000000,  // search drag id
    S_DWRITE = 11'b00100000000,
    S_FOCUS  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0] scr_w_r, scr_h_r;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [31:0] focus_r, focus_nxt;
  logic [CB-1:0] px_r, px_nxt, py_r, py_nxt;
  logic held_r, held_nxt;
  logic [31:0] drag_id_r, drag_id_nxt;
  logic signed [16:0] doff_x_r, doff_x_nxt, doff_y_r, doff_y_nxt;

  logic [2:0] req_r;
  logic [31:0] id_r;
  logic [15:0] posx_r, posy_r;
  logic [14:0] sw_r, sh_r;
  logic [1:0] status_r, status_nxt;
  logic out_valid_r, out_valid_nxt;

  // pass control
  logic [DW-1:0] idx_r, idx_nxt;       // address issued
  logic rv_r, rv_nxt;                  // read data valid next cycle
  logic [AW-1:0] ridx_r, ridx_nxt;     // address of data on rdata
  logic [AW-1:0] hit_r, hit_nxt;
  logic close_r, close_nxt;            // closing after raise
  slot_t save_r, save_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  slot_t wdata, rdata;

  wsm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_WINDOWS)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // config port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_comb begin
    case (cfg_paddr[2])
      ADDR_SCREEN_W: cfg_prdata = {19'd0, scr_w_r};
      ADDR_SCREEN_H: cfg_prdata = {19'd0, scr_h_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  function automatic logic [CB-1:0] half_lim(input logic [12:0] reg_v);
    logic [15:0] lim;
    logic [15:0] h;
    begin
      lim = (reg_v == 13'd0) ? 16'd1 : {3'b0, reg_v};
      if (lim > 16'(1 << CB)) lim = 16'(1 << CB);
      h = {4'b0, reg_v[12:1]};
      if (h > lim - 16'd1) h = lim - 16'd1;
      half_lim = h[CB-1:0];
    end
  endfunction

  function automatic logic [CB-1:0] clamp_mv(input logic [CB-1:0] p,
      input logic signed [15:0] d, input logic [12:0] reg_v);
    logic signed [17:0] s;
    logic signed [17:0] mx;
    logic [15:0] lim;
    begin
      lim = (reg_v == 13'd0) ? 16'd1 : {3'b0, reg_v};
      if (lim > 16'(1 << CB)) lim = 16'(1 << CB);
      mx = $signed({2'd0, lim}) - 18'sd1;
      s = $signed({{(18-CB){1'b0}}, p}) + 18'(d);
      if (s < 0) s = 18'sd0;
      else if (s > mx) s = mx;
      clamp_mv = s[CB-1:0];
    end
  endfunction

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    begin
      if (v < -18'sd32768) sat16 = 16'h8000;
      else if (v > 18'sd32767) sat16 = 16'h7FFF;
      else sat16 = v[15:0];
    end
  endfunction

  // hit test on read data
  logic signed [16:0] pxs, pys, rl, rt;
  logic signed [17:0] rr, rb, cx, cy;
  logic hit_in, close_in, title_in;
  always_comb begin
    pxs = $signed({{(17-CB){1'b0}}, px_r});
    pys = $signed({{(17-CB){1'b0}}, py_r});
    rl = 17'($signed(rdata.left));
    rt = 17'($signed(rdata.top));
    rr = 18'(rl) + $signed({3'd0, rdata.width});
    rb = 18'(rt) + $signed({3'd0, rdata.height});
    cx = rr - 18'(CLOSE_INSET);
    cy = 18'(rt) + 18'(CLOSE_TOP);
    hit_in = (pxs >= rl) && (18'(pxs) < rr) && (pys >= rt) && (18'(pys) < rb);
    close_in = (18'(pxs) >= cx) && (18'(pxs) < cx + 18'(CLOSE_SIZE)) &&
               (18'(pys) >= cy) && (18'(pys) < cy + 18'(CLOSE_SIZE));
    title_in = 18'(pys) < 18'(rt) + 18'(TITLE_H + BORDER_W);
  end

  logic in_fire, out_fire;
  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  logic [DW-1:0] last;
  assign last = depth_r - DW'(1);

  always_comb begin
    state_nxt = state_r;
    depth_nxt = depth_r;
    focus_nxt = focus_r;
    px_nxt = px_r;
    py_nxt = py_r;
    held_nxt = held_r;
    drag_id_nxt = drag_id_r;
    doff_x_nxt = doff_x_r;
    doff_y_nxt = doff_y_r;
    status_nxt = status_r;
    out_valid_nxt = out_valid_r;
    idx_nxt = idx_r;
    rv_nxt = 1'b0;
    ridx_nxt = idx_r[AW-1:0];
    hit_nxt = hit_r;
    close_nxt = close_r;
    save_nxt = save_r;
    we = 1'b0;
    waddr = ridx_r;
    wdata = rdata;
    raddr = idx_r[AW-1:0];
    if (out_fire) out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = ST_DONE;
          close_nxt = 1'b0;
          case (in_req_type)
            REQ_CREATE: begin
              if (depth_r >= DW'(MAX_WINDOWS)) begin
                status_nxt = ST_FULL;
              end else begin
                we = 1'b1;
                waddr = depth_r[AW-1:0];
                wdata = '{in_win_id, in_pos_x, in_pos_y, in_size_w, in_size_h,
                          in_fill_color};
                depth_nxt = depth_r + DW'(1);
                focus_nxt = in_win_id;
              end
              state_nxt = S_OUT;
            end
            REQ_DESTROY, REQ_MOVE, REQ_RESIZE, REQ_RAISE: begin
              idx_nxt = '0;
              state_nxt = S_FIND;
            end
            REQ_MOTION: begin
              if (in_move_dx != 16'sd0 || in_move_dy != 16'sd0) begin
                px_nxt = clamp_mv(px_r, in_move_dx, scr_w_r);
                py_nxt = clamp_mv(py_r, in_move_dy, scr_h_r);
              end
              idx_nxt = '0;
              state_nxt = S_DFIND;
            end
            REQ_BUTTON: begin
              if (in_button_pressed && !held_r) begin
                held_nxt = 1'b1;
                idx_nxt = last;
                state_nxt = (depth_r == '0) ? S_DFIND : S_HIT;
                if (depth_r == '0) idx_nxt = '0;
              end else begin
                if (!in_button_pressed && held_r) begin
                  held_nxt = 1'b0;
                  drag_id_nxt = '0;
                end
                idx_nxt = '0;
                state_nxt = S_DFIND;
              end
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_FIND: begin
        if (rv_r && rdata.id == id_r) begin
          hit_nxt = ridx_r;
          save_nxt = rdata;
          state_nxt = S_APPLY;
        end else if (idx_r < depth_r) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r + DW'(1);
        end else if (!rv_r) begin
          status_nxt = ST_NOTFOUND;
          state_nxt = S_OUT;
        end
      end
      S_APPLY: begin
        case (req_r)
          REQ_MOVE: begin
            we = 1'b1; waddr = hit_r; wdata = save_r;
            wdata.left = posx_r; wdata.top = posy_r;
            state_nxt = S_OUT;
          end
          REQ_RESIZE: begin
            we = 1'b1; waddr = hit_r; wdata = save_r;
            wdata.width = sw_r; wdata.height = sh_r;
            state_nxt = S_OUT;
          end
          default: begin
            idx_nxt = DW'(hit_r) + DW'(1);
            state_nxt = S_SHIFT;
          end
        endcase
      end
      S_SHIFT: begin
        if (rv_r) begin
          we = 1'b1;
          waddr = ridx_r - AW'(1);
          wdata = rdata;
        end
        if (idx_r < depth_r) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r + DW'(1);
        end else if (!rv_r) begin
          if (req_r == REQ_DESTROY) begin
            depth_nxt = last;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_PUTTOP;
          end
        end
      end
      S_PUTTOP: begin
        we = 1'b1;
        waddr = last[AW-1:0];
        wdata = save_r;
        focus_nxt = save_r.id;
        if (req_r == REQ_BUTTON && close_r) begin
          depth_nxt = last;
          if (last == '0) begin
            focus_nxt = '0;
            idx_nxt = '0;
            state_nxt = S_DFIND;
          end else begin
            idx_nxt = last - DW'(1);
            state_nxt = S_FOCUS;
          end
        end else if (req_r == REQ_BUTTON) begin
          idx_nxt = '0;
          state_nxt = S_DFIND;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_FOCUS: begin
        if (rv_r) begin
          focus_nxt = rdata.id;
          idx_nxt = '0;
          state_nxt = S_DFIND;
        end else begin
          rv_nxt = 1'b1;
        end
      end
      S_HIT: begin
        if (rv_r && hit_in) begin
          hit_nxt = ridx_r;
          save_nxt = rdata;
          state_nxt = S_PRESS;
          if (close_in) begin
            close_nxt = 1'b1;
          end else if (title_in) begin
            drag_id_nxt = rdata.id;
            doff_x_nxt = pxs - rl;
            doff_y_nxt = pys - rt;
          end
        end else if (!rv_r || ridx_r != '0) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r - DW'(1);
          if (rv_r) ridx_nxt = ridx_r - AW'(1);
          else ridx_nxt = idx_r[AW-1:0];
          raddr = rv_r ? ridx_r - AW'(1) : idx_r[AW-1:0];
        end else begin
          idx_nxt = '0;
          state_nxt = S_DFIND;
        end
      end
      S_PRESS: begin
        idx_nxt = DW'(hit_r) + DW'(1);
        state_nxt = S_SHIFT;
      end
      S_DFIND: begin
        if (!held_r || drag_id_r == '0) begin
          state_nxt = S_OUT;
        end else if (rv_r && rdata.id == drag_id_r) begin
          hit_nxt = ridx_r;
          save_nxt = rdata;
          state_nxt = S_DWRITE;
        end else if (idx_r < depth_r) begin
          rv_nxt = 1'b1;
          idx_nxt = idx_r + DW'(1);
        end else if (!rv_r) begin
          state_nxt = S_OUT;
        end
      end
      S_DWRITE: begin
        we = 1'b1; waddr = hit_r; wdata = save_r;
        wdata.left = sat16(18'($signed({1'b0, px_r})) - 18'(doff_x_r));
        wdata.top = sat16(18'($signed({1'b0, py_r})) - 18'(doff_y_r));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      scr_w_r <= SCREEN_W_RST;
      scr_h_r <= SCREEN_H_RST;
      depth_r <= '0;
      focus_r <= '0;
      px_r <= half_lim(SCREEN_W_RST);
      py_r <= half_lim(SCREEN_H_RST);
      held_r <= 1'b0;
      drag_id_r <= '0;
      doff_x_r <= '0;
      doff_y_r <= '0;
      out_valid_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr[2] == ADDR_SCREEN_W) scr_w_r <= cfg_pwdata[12:0];
      if (cfg_wr && cfg_paddr[2] == ADDR_SCREEN_H) scr_h_r <= cfg_pwdata[12:0];
      depth_r <= depth_nxt;
      focus_r <= focus_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      held_r <= held_nxt;
      drag_id_r <= drag_id_nxt;
      doff_x_r <= doff_x_nxt;
      doff_y_r <= doff_y_nxt;
      out_valid_r <= out_valid_nxt;
      rv_r <= rv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_req_type;
      id_r <= in_win_id;
      posx_r <= in_pos_x;
      posy_r <= in_pos_y;
      sw_r <= in_size_w;
      sh_r <= in_size_h;
    end
    status_r <= status_nxt;
    idx_r <= idx_nxt;
    ridx_r <= ridx_nxt;
    hit_r <= hit_nxt;
    close_r <= close_nxt;
    save_r <= save_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_focused_window = focus_r;
  assign out_cursor_x = px_r;
  assign out_cursor_y = py_r;
  assign out_window_total = depth_r;
  assign out_dragging = held_r && (drag_id_r != '0);

`ifndef ASSERT_OFF
  a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(MAX_WINDOWS)) else $error("stack depth over limit");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE)) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !out_valid_r) else $error("result overrun");
`endif
endmodule
`default_nettype wire

[hdl/wsm_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module wsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
